/* rtl/core/snr_pkg.sv */
package snr_pkg;

    localparam int ID_W    = 26;
    localparam int COORD_W = 32;
    localparam int STAT_W  = 3;

    localparam int DEF_NUM_GROUPS       = 1024;
    localparam int DEF_CHUNKS_PER_GROUP = 256;
    localparam int DEF_NODES_PER_CHUNK  = 256;
    localparam int DEF_MAX_CHUNKS       = 4096;
    localparam int DEF_MAX_ENTRIES      = 65536;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_GROUP = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_CHUNK = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_NODE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_REOPEN   = 3'd4;
    localparam logic [STAT_W-1:0] ST_ORDER    = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic clr;
        logic ld;
        logic ins;
        logic lg;
        logic rg;
        logic gs;
        logic rc;
        logic cs;
        logic er;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic fail;
    } t_stat;

    function automatic logic [6:0] cnt64(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int k = 0; k < 64; k++) begin
            n = n + 7'(v[k]);
        end
        return n;
    endfunction

endpackage

/* rtl/core/snr_if.sv */
interface snr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [snr_pkg::ID_W-1:0]      node_id;
    logic signed [snr_pkg::COORD_W-1:0] latp;
    logic signed [snr_pkg::COORD_W-1:0] lon;
    modport source (output valid, action, node_id, latp, lon, input ready);
    modport sink   (input valid, action, node_id, latp, lon, output ready);
endinterface

interface snr_out_if;
    logic                          valid;
    logic                          ready;
    logic [snr_pkg::STAT_W-1:0]    status;
    logic signed [snr_pkg::COORD_W-1:0] found_latp;
    logic signed [snr_pkg::COORD_W-1:0] found_lon;
    modport source (output valid, status, found_latp, found_lon, input ready);
    modport sink   (input valid, status, found_latp, found_lon, output ready);
endinterface

/* rtl/core/snr_rank.sv */
module snr_rank #(
    parameter int W = 256
) (
    input  logic                   i_clk,
    input  logic                   i_ld,
    input  logic [W-1:0]           i_vec,
    input  logic [$clog2(W)-1:0]   i_pos,
    output logic                   o_hit,
    output logic [$clog2(W):0]     o_rank
);
    import snr_pkg::*;

    localparam int PW   = $clog2(W);
    localparam int LANE = (W < 64) ? W : 64;
    localparam int NL   = W / LANE;

    logic [W-1:0] w_mask;
    logic [6:0]   r_cnt [NL];
    logic         r_hit;

    // bits strictly below the probed position
    always_comb begin
        for (int k = 0; k < W; k++) begin
            w_mask[k] = i_vec[k] && (PW'(k) < i_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_hit <= i_vec[i_pos];
            for (int l = 0; l < NL; l++) begin
                r_cnt[l] <= cnt64(64'(w_mask[l*LANE +: LANE]));
            end
        end
    end

    always_comb begin
        o_rank = '0;
        for (int l = 0; l < NL; l++) begin
            o_rank = o_rank + (PW+1)'(r_cnt[l]);
        end
    end

    assign o_hit = r_hit;
endmodule

/* rtl/core/snr_ctrl.sv */
module snr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_act,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output snr_pkg::t_cmd    o_cmd,
    input  snr_pkg::t_stat   i_stat
);
    import snr_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INS  = 4'd1;
    localparam logic [3:0] S_LG   = 4'd2;
    localparam logic [3:0] S_GR   = 4'd3;
    localparam logic [3:0] S_GS   = 4'd4;
    localparam logic [3:0] S_CR   = 4'd5;
    localparam logic [3:0] S_CS   = 4'd6;
    localparam logic [3:0] S_ER   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;
    localparam logic [3:0] S_CLR  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_ov, n_ov;
    logic       w_free;

    assign w_free      = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !i_out_ready;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld = 1'b1;
                    n_state  = (i_act == ACT_LOOKUP) ? S_LG : S_INS;
                end
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_DONE;
            end
            S_LG: begin
                o_cmd.lg = 1'b1;
                n_state  = i_stat.fail ? S_DONE : S_GR;
            end
            S_GR: begin
                o_cmd.rg = 1'b1;
                n_state  = i_stat.fail ? S_DONE : S_GS;
            end
            S_GS: begin
                o_cmd.gs = 1'b1;
                n_state  = i_stat.fail ? S_DONE : S_CR;
            end
            S_CR: begin
                o_cmd.rc = 1'b1;
                n_state  = S_CS;
            end
            S_CS: begin
                o_cmd.cs = 1'b1;
                n_state  = i_stat.fail ? S_DONE : S_ER;
            end
            S_ER: begin
                o_cmd.er = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (w_free) begin
                    o_cmd.out = 1'b1;
                    n_ov      = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end
endmodule

/* rtl/core/snr_dp.sv */
module snr_dp #(
    parameter int NUM_GROUPS       = snr_pkg::DEF_NUM_GROUPS,
    parameter int CHUNKS_PER_GROUP = snr_pkg::DEF_CHUNKS_PER_GROUP,
    parameter int NODES_PER_CHUNK  = snr_pkg::DEF_NODES_PER_CHUNK,
    parameter int MAX_CHUNKS       = snr_pkg::DEF_MAX_CHUNKS,
    parameter int MAX_ENTRIES      = snr_pkg::DEF_MAX_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  snr_pkg::t_cmd                      i_cmd,
    output snr_pkg::t_stat                     o_stat,
    input  logic [snr_pkg::ID_W-1:0]           i_node_id,
    input  logic signed [snr_pkg::COORD_W-1:0] i_latp,
    input  logic signed [snr_pkg::COORD_W-1:0] i_lon,
    output logic [snr_pkg::STAT_W-1:0]         o_status,
    output logic signed [snr_pkg::COORD_W-1:0] o_found_latp,
    output logic signed [snr_pkg::COORD_W-1:0] o_found_lon
);
    import snr_pkg::*;

    localparam int NW  = $clog2(NODES_PER_CHUNK);
    localparam int CW  = $clog2(CHUNKS_PER_GROUP);
    localparam int GW  = ID_W - NW - CW;
    localparam int GIW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int GXW = (GIW > GW) ? GIW : GW;
    localparam int CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CSW = $clog2(MAX_CHUNKS + 1);
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ESW = $clog2(MAX_ENTRIES + 1);
    localparam int SLW = ((CIW > CW + 1) ? CIW : CW + 1) + 1;
    localparam int ELW = ((EIW > NW + 1) ? EIW : NW + 1) + 1;

    logic                        m_gpres  [NUM_GROUPS];
    logic [CHUNKS_PER_GROUP-1:0] m_gbits  [NUM_GROUPS];
    logic [CIW-1:0]              m_gfirst [NUM_GROUPS];
    logic [NODES_PER_CHUNK-1:0]  m_cbits  [MAX_CHUNKS];
    logic [EIW-1:0]              m_cfirst [MAX_CHUNKS];
    logic [COORD_W-1:0]          m_latp   [MAX_ENTRIES];
    logic [COORD_W-1:0]          m_lon    [MAX_ENTRIES];

    logic [ID_W-1:0]             r_id, r_last;
    logic [COORD_W-1:0]          r_latp, r_lon;
    logic                        r_any;
    logic [CSW-1:0]              r_nc;
    logic [ESW-1:0]              r_ne;
    logic [GIW-1:0]              r_clr;
    logic [CHUNKS_PER_GROUP-1:0] r_curg;
    logic [NODES_PER_CHUNK-1:0]  r_curc;
    logic                        r_gp_q;
    logic [CHUNKS_PER_GROUP-1:0] r_gb_q;
    logic [CIW-1:0]              r_gf_q;
    logic [NODES_PER_CHUNK-1:0]  r_cb_q;
    logic [EIW-1:0]              r_cf_q;
    logic [COORD_W-1:0]          r_el_q, r_eo_q;
    logic [STAT_W-1:0]           r_st;
    logic [COORD_W-1:0]          r_fl, r_fo;
    logic [STAT_W-1:0]           r_ost;
    logic [COORD_W-1:0]          r_ofl, r_ofo;

    logic [NW-1:0]  w_n;
    logic [CW-1:0]  w_c, w_lc;
    logic [GXW:0]   w_g, w_lg;
    logic           w_g_oob, w_new_g, w_new_c;
    logic           w_order, w_reopen, w_full_c, w_full_e;
    logic [STAT_W-1:0] w_ins_st;
    logic [CIW-1:0] w_wslot;
    logic [GIW-1:0] w_gi;
    logic [GIW-1:0] w_gp_addr;
    logic           w_gp_we, w_gp_d;
    logic [CW:0]    w_grank;
    logic [NW:0]    w_crank;
    logic           w_ghit, w_chit;
    logic [SLW-1:0] w_slot;
    logic [ELW-1:0] w_entry;
    logic           w_slot_bad, w_entry_bad;

    assign w_n  = r_id[NW-1:0];
    assign w_c  = r_id[NW +: CW];
    assign w_lc = r_last[NW +: CW];
    assign w_g  = (GXW+1)'(r_id[ID_W-1 -: GW]);
    assign w_lg = (GXW+1)'(r_last[ID_W-1 -: GW]);
    assign w_gi = w_g[GIW-1:0];

    assign w_g_oob   = w_g >= (GXW+1)'(NUM_GROUPS);
    assign w_order   = r_any && (r_id <= r_last);
    assign w_new_g   = !r_any || (w_g != w_lg);
    // groups open in ascending order, so every open group is at or below the last one
    assign w_reopen  = w_new_g && r_any && (w_g <= w_lg);
    assign w_new_c   = w_new_g || (w_c != w_lc);
    assign w_full_c  = w_new_c && (r_nc >= CSW'(MAX_CHUNKS));
    assign w_full_e  = r_ne >= ESW'(MAX_ENTRIES);
    assign w_wslot   = w_new_c ? r_nc[CIW-1:0] : CIW'(r_nc - CSW'(1));

    always_comb begin
        if (w_order) begin
            w_ins_st = ST_ORDER;
        end else if (w_g_oob) begin
            w_ins_st = ST_FULL;
        end else if (w_reopen) begin
            w_ins_st = ST_REOPEN;
        end else if (w_full_c || w_full_e) begin
            w_ins_st = ST_FULL;
        end else begin
            w_ins_st = ST_OK;
        end
    end

    // group presence: cleared after reset, set when a group opens
    assign w_gp_addr = i_cmd.clr ? r_clr : w_gi;
    assign w_gp_we   = i_cmd.clr || (i_cmd.ins && w_ins_st == ST_OK && w_new_g);
    assign w_gp_d    = !i_cmd.clr;

    snr_rank #(.W(CHUNKS_PER_GROUP)) u_grank (
        .i_clk (i_clk),
        .i_ld  (i_cmd.rg),
        .i_vec (r_gb_q),
        .i_pos (w_c),
        .o_hit (w_ghit),
        .o_rank(w_grank)
    );

    snr_rank #(.W(NODES_PER_CHUNK)) u_crank (
        .i_clk (i_clk),
        .i_ld  (i_cmd.rc),
        .i_vec (r_cb_q),
        .i_pos (w_n),
        .o_hit (w_chit),
        .o_rank(w_crank)
    );

    assign w_slot      = SLW'(r_gf_q) + SLW'(w_grank);
    assign w_slot_bad  = !w_ghit || (w_slot >= SLW'(MAX_CHUNKS));
    assign w_entry     = ELW'(r_cf_q) + ELW'(w_crank);
    assign w_entry_bad = !w_chit || (w_entry >= ELW'(MAX_ENTRIES));

    always_comb begin
        o_stat.fail     = 1'b0;
        o_stat.clr_done = i_cmd.clr && (r_clr == GIW'(NUM_GROUPS - 1));
        if (i_cmd.lg) begin
            o_stat.fail = w_g_oob;
        end else if (i_cmd.rg) begin
            o_stat.fail = !r_gp_q;
        end else if (i_cmd.gs) begin
            o_stat.fail = w_slot_bad;
        end else if (i_cmd.cs) begin
            o_stat.fail = w_entry_bad;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_gp_we) begin
            m_gpres[w_gp_addr] <= w_gp_d;
        end
        if (i_cmd.ins && w_ins_st == ST_OK) begin
            if (w_new_g) begin
                m_gfirst[w_gi] <= r_nc[CIW-1:0];
                m_gbits[w_gi]  <= CHUNKS_PER_GROUP'(1) << w_c;
            end else if (w_new_c) begin
                m_gbits[w_gi]  <= r_curg | (CHUNKS_PER_GROUP'(1) << w_c);
            end
            if (w_new_c) begin
                m_cfirst[w_wslot] <= r_ne[EIW-1:0];
                m_cbits[w_wslot]  <= NODES_PER_CHUNK'(1) << w_n;
            end else begin
                m_cbits[w_wslot]  <= r_curc | (NODES_PER_CHUNK'(1) << w_n);
            end
            m_latp[r_ne[EIW-1:0]] <= r_latp;
            m_lon[r_ne[EIW-1:0]]  <= r_lon;
        end
        if (i_cmd.lg) begin
            r_gp_q <= m_gpres[w_gi];
            r_gb_q <= m_gbits[w_gi];
            r_gf_q <= m_gfirst[w_gi];
        end
        if (i_cmd.gs) begin
            r_cb_q <= m_cbits[w_slot[CIW-1:0]];
            r_cf_q <= m_cfirst[w_slot[CIW-1:0]];
        end
        if (i_cmd.cs) begin
            r_el_q <= m_latp[w_entry[EIW-1:0]];
            r_eo_q <= m_lon[w_entry[EIW-1:0]];
        end
    end

    // payload and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_id   <= i_node_id;
            r_latp <= i_latp;
            r_lon  <= i_lon;
            r_fl   <= '0;
            r_fo   <= '0;
        end
        if (i_cmd.ins) begin
            r_st <= w_ins_st;
            if (w_ins_st == ST_OK) begin
                r_curg <= (w_new_g ? '0 : r_curg) | (CHUNKS_PER_GROUP'(1) << w_c);
                r_curc <= (w_new_c ? '0 : r_curc) | (NODES_PER_CHUNK'(1) << w_n);
            end
        end
        if (i_cmd.lg) begin
            r_st <= ST_NO_GROUP;
        end
        if (i_cmd.gs) begin
            r_st <= ST_NO_CHUNK;
        end
        if (i_cmd.cs) begin
            r_st <= ST_NO_NODE;
        end
        if (i_cmd.er) begin
            r_st <= ST_OK;
            r_fl <= r_el_q;
            r_fo <= r_eo_q;
        end
        if (i_cmd.out) begin
            r_ost <= r_st;
            r_ofl <= r_fl;
            r_ofo <= r_fo;
        end
    end

    // store counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any  <= 1'b0;
            r_last <= '0;
            r_nc   <= '0;
            r_ne   <= '0;
        end else if (i_cmd.ins && w_ins_st == ST_OK) begin
            r_any  <= 1'b1;
            r_last <= r_id;
            r_ne   <= r_ne + ESW'(1);
            if (w_new_c) begin
                r_nc <= r_nc + CSW'(1);
            end
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + GIW'(1);
        end
    end

    assign o_status     = r_ost;
    assign o_found_latp = r_ofl;
    assign o_found_lon  = r_ofo;
endmodule

/* rtl/core/sparse_bitmap_rank_node_store.sv */
// channel  dir  handshake     payload
// i_in     in   valid/ready   action, node_id, latp, lon
// o_out    out  valid/ready   status, found_latp, found_lon
//
// one transaction in flight; an insert takes an insert step, then its result is registered;
// a lookup runs the steps below (a group beyond the store fails at the first one):
// three dependent registered memory reads (group, chunk, coordinate entry),
// the first two each followed by a registered popcount rank; a miss ends early
// a waiting result holds the output register; the next transaction is accepted
// meanwhile and stalls only at its own result until the output is taken
// synchronous active-low reset clears control and counters, then the input is held
// off while the group presence memory is cleared
module sparse_bitmap_rank_node_store #(
    parameter int NUM_GROUPS       = snr_pkg::DEF_NUM_GROUPS,
    parameter int CHUNKS_PER_GROUP = snr_pkg::DEF_CHUNKS_PER_GROUP,
    parameter int NODES_PER_CHUNK  = snr_pkg::DEF_NODES_PER_CHUNK,
    parameter int MAX_CHUNKS       = snr_pkg::DEF_MAX_CHUNKS,
    parameter int MAX_ENTRIES      = snr_pkg::DEF_MAX_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    snr_in_if.sink    i_in,
    snr_out_if.source o_out
);
    import snr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    snr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_act      (i_in.action),
        .o_in_ready (i_in.ready),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    snr_dp #(
        .NUM_GROUPS      (NUM_GROUPS),
        .CHUNKS_PER_GROUP(CHUNKS_PER_GROUP),
        .NODES_PER_CHUNK (NODES_PER_CHUNK),
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MAX_ENTRIES     (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_node_id   (i_in.node_id),
        .i_latp      (i_in.latp),
        .i_lon       (i_in.lon),
        .o_status    (o_out.status),
        .o_found_latp(o_out.found_latp),
        .o_found_lon (o_out.found_lon)
    );
endmodule

/* rtl/core/snr_chk.sv */
module snr_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [snr_pkg::STAT_W-1:0]         i_status,
    input logic signed [snr_pkg::COORD_W-1:0] i_found_latp,
    input logic signed [snr_pkg::COORD_W-1:0] i_found_lon
);
    import snr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_found_latp == '0 && i_found_lon == '0)
        else $error("nonzero coordinates on failed transaction");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result earlier than possible");
endmodule

bind sparse_bitmap_rank_node_store snr_chk u_snr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_found_latp(o_out.found_latp),
    .i_found_lon (o_out.found_lon)
);

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import snr_pkg::*;

    localparam int N_GROUPS   = DEF_NUM_GROUPS;
    localparam int N_CHUNKS   = DEF_MAX_CHUNKS;
    localparam int N_ENTRIES  = DEF_MAX_ENTRIES;
    localparam int CYCLE_CAP  = 2_500_000;
    localparam int N_RANDOM   = 700;

    typedef struct {
        logic [STAT_W-1:0]         st;
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lon;
    } coord_result_t;

    typedef struct {
        logic                      act;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lon;
        bit                        typed;
        coord_result_t             res;
    } store_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #6 i_clk = ~i_clk;

    snr_in_if  in_ch();
    snr_out_if out_ch();

    sparse_bitmap_rank_node_store u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // shadow of the store
    bit                        grp_open [N_GROUPS];
    logic [255:0]              grp_chunk_map [N_GROUPS];
    int unsigned               grp_base_slot [N_GROUPS];
    logic [255:0]              slot_node_map [N_CHUNKS];
    int unsigned               slot_base_entry [N_CHUNKS];
    logic signed [COORD_W-1:0] coord_lat [N_ENTRIES];
    logic signed [COORD_W-1:0] coord_lon [N_ENTRIES];
    int unsigned               chunks_used = 0;
    int unsigned               entries_used = 0;
    logic [ID_W-1:0]           newest_id = '0;
    bit                        have_inserted = 1'b0;

    coord_result_t   pending_results[$];
    logic [ID_W-1:0] stored_ids[$];
    int              src_idle = 0;
    int              snk_stall = 0;
    int              fail_count = 0;
    int              result_count = 0;
    int              ok_lookups = 0;
    int              cycle_count = 0;

    function automatic int unsigned rank_below(input logic [255:0] map, input int unsigned pos);
        logic [255:0] lower;
        lower = (256'd1 << pos) - 256'd1;
        return 32'($countones(map & lower));
    endfunction

    function automatic coord_result_t store_node(input logic [ID_W-1:0] id,
                                                 input logic signed [COORD_W-1:0] lat,
                                                 input logic signed [COORD_W-1:0] lon);
        coord_result_t r;
        int unsigned g, c, n, lg, lc, slot;
        bit new_grp, new_chk;
        r = '{ST_OK, '0, '0};
        if (have_inserted && id <= newest_id) begin
            r.st = ST_ORDER;
            return r;
        end
        n = 32'(id[7:0]);
        c = 32'(id[15:8]);
        g = 32'(id[ID_W-1:16]);
        if (g >= N_GROUPS) begin
            r.st = ST_FULL;
            return r;
        end
        lc = 32'(newest_id[15:8]);
        lg = 32'(newest_id[ID_W-1:16]);
        new_grp = !have_inserted || g != lg;
        if (new_grp && grp_open[g]) begin
            r.st = ST_REOPEN;
            return r;
        end
        new_chk = new_grp || c != lc;
        if ((new_chk && chunks_used >= N_CHUNKS) || entries_used >= N_ENTRIES) begin
            r.st = ST_FULL;
            return r;
        end
        if (new_grp) begin
            grp_open[g] = 1'b1;
            grp_chunk_map[g] = '0;
            grp_base_slot[g] = chunks_used;
        end
        if (new_chk) begin
            slot = chunks_used;
            slot_node_map[slot] = '0;
            slot_base_entry[slot] = entries_used;
            grp_chunk_map[g][c] = 1'b1;
            chunks_used++;
        end else begin
            slot = chunks_used - 32'd1;
        end
        slot_node_map[slot][n] = 1'b1;
        coord_lat[entries_used] = lat;
        coord_lon[entries_used] = lon;
        entries_used++;
        newest_id = id;
        have_inserted = 1'b1;
        return r;
    endfunction

    function automatic coord_result_t find_node(input logic [ID_W-1:0] id);
        coord_result_t r;
        int unsigned g, c, n, slot, entry;
        r = '{ST_OK, '0, '0};
        n = 32'(id[7:0]);
        c = 32'(id[15:8]);
        g = 32'(id[ID_W-1:16]);
        if (g >= N_GROUPS || !grp_open[g]) begin
            r.st = ST_NO_GROUP;
            return r;
        end
        if (!grp_chunk_map[g][c]) begin
            r.st = ST_NO_CHUNK;
            return r;
        end
        slot = grp_base_slot[g] + rank_below(grp_chunk_map[g], c);
        if (slot >= N_CHUNKS) begin
            r.st = ST_NO_CHUNK;
            return r;
        end
        if (!slot_node_map[slot][n]) begin
            r.st = ST_NO_NODE;
            return r;
        end
        entry = slot_base_entry[slot] + rank_below(slot_node_map[slot], n);
        if (entry >= N_ENTRIES) begin
            r.st = ST_NO_NODE;
            return r;
        end
        r.lat = coord_lat[entry];
        r.lon = coord_lon[entry];
        return r;
    endfunction

    task automatic send_node(input logic act, input logic [ID_W-1:0] id,
                             input logic signed [COORD_W-1:0] lat,
                             input logic signed [COORD_W-1:0] lon,
                             input bit typed, input coord_result_t typed_res);
        coord_result_t r;
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.node_id <= id;
        in_ch.latp    <= lat;
        in_ch.lon     <= lon;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (act == ACT_INSERT) begin
            r = store_node(id, lat, lon);
            if (r.st == ST_OK && stored_ids.size() < 4000)
                stored_ids.insert(stored_ids.size(), id);
        end else begin
            r = find_node(id);
            if (r.st == ST_OK) ok_lookups++;
        end
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic send_checked(input logic act, input logic [ID_W-1:0] id,
                                input logic signed [COORD_W-1:0] lat,
                                input logic signed [COORD_W-1:0] lon);
        send_node(act, id, lat, lon, 1'b0, '{ST_OK, '0, '0});
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic random_mix(input int count);
        logic [ID_W-1:0] id;
        int unsigned     r;
        int unsigned     back;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if ($urandom_range(1)) begin
                if (!have_inserted) begin
                    id = ID_W'($urandom_range(1000));
                end else if (r < 8) begin
                    back = (newest_id < 300) ? 32'(newest_id) : 32'd300;
                    id = ID_W'(newest_id - $urandom_range(back));
                end else if (r < 15 && newest_id[ID_W-1:16] < 900) begin
                    id = {newest_id[ID_W-1:16] + 10'd1, 16'($urandom_range(65535))};
                end else if (r < 35) begin
                    id = ID_W'(((newest_id >> 8) + $urandom_range(1, 3)) << 8);
                    id[7:0] = 8'($urandom_range(255));
                end else begin
                    id = ID_W'(newest_id + $urandom_range(1, 4));
                end
                send_checked(ACT_INSERT, id, $urandom, $urandom);
            end else begin
                if (r < 45 && stored_ids.size() != 0)
                    id = stored_ids[$urandom_range(stored_ids.size() - 1)];
                else if (r < 65)
                    id = ID_W'(newest_id - $urandom_range(2000) + 1000);
                else
                    id = ID_W'($urandom);
                send_checked(ACT_LOOKUP, id, $urandom, $urandom);
            end
        end
    endtask

    store_row_t dir_rows[17] = '{
        '{ACT_LOOKUP, 26'd0,        '0, '0, 1'b1, '{ST_NO_GROUP, '0, '0}},
        '{ACT_LOOKUP, 26'h3ffffff,  '0, '0, 1'b1, '{ST_NO_GROUP, '0, '0}},
        '{ACT_INSERT, 26'd0, 32'sh80000000, 32'sh7fffffff, 1'b1, '{ST_OK, '0, '0}},
        '{ACT_INSERT, 26'd0,        32'sd5, 32'sd6, 1'b1, '{ST_ORDER, '0, '0}},
        '{ACT_LOOKUP, 26'd0,        '0, '0, 1'b1,
          '{ST_OK, 32'sh80000000, 32'sh7fffffff}},
        '{ACT_LOOKUP, 26'd1,        '0, '0, 1'b1, '{ST_NO_NODE, '0, '0}},
        '{ACT_LOOKUP, 26'd256,      '0, '0, 1'b1, '{ST_NO_CHUNK, '0, '0}},
        '{ACT_LOOKUP, 26'd65536,    '0, '0, 1'b1, '{ST_NO_GROUP, '0, '0}},
        '{ACT_INSERT, 26'd255, 32'sh7fffffff, 32'sh80000000, 1'b1, '{ST_OK, '0, '0}},
        '{ACT_INSERT, 26'd65280,    -32'sd1, 32'sd0, 1'b1, '{ST_OK, '0, '0}},
        '{ACT_INSERT, 26'd65535,    32'sd1, -32'sd1, 1'b1, '{ST_OK, '0, '0}},
        '{ACT_LOOKUP, 26'd255,      '0, '0, 1'b1,
          '{ST_OK, 32'sh7fffffff, 32'sh80000000}},
        '{ACT_LOOKUP, 26'd65535,    '0, '0, 1'b1, '{ST_OK, 32'sd1, -32'sd1}},
        '{ACT_INSERT, 26'd100,      32'sd7, 32'sd8, 1'b1, '{ST_ORDER, '0, '0}},
        '{ACT_INSERT, 26'd65536,    32'sd9, 32'sd10, 1'b1, '{ST_OK, '0, '0}},
        '{ACT_LOOKUP, 26'd65280,    '0, '0, 1'b0, '{ST_OK, '0, '0}},
        '{ACT_LOOKUP, 26'd128,      '0, '0, 1'b0, '{ST_OK, '0, '0}}
    };

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    always @(posedge i_clk) begin
        coord_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction st=%0d lat=%0d lon=%0d", $time,
                         out_ch.status, out_ch.found_latp, out_ch.found_lon);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.st || out_ch.found_latp !== want.lat
                        || out_ch.found_lon !== want.lon) begin
                    $display("%0t: expected st=%0d lat=%0d lon=%0d, got st=%0d lat=%0d lon=%0d",
                             $time, want.st, want.lat, want.lon,
                             out_ch.status, out_ch.found_latp, out_ch.found_lon);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int waited;
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_INSERT;
        in_ch.node_id = '0;
        in_ch.latp    = '0;
        in_ch.lon     = '0;
        out_ch.ready  = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_node(dir_rows[k].act, dir_rows[k].id, dir_rows[k].lat, dir_rows[k].lon,
                      dir_rows[k].typed, dir_rows[k].res);
        drain_results();

        src_idle = 0;  snk_stall = 0;  random_mix(N_RANDOM / 4);  drain_results();
        src_idle = 51; snk_stall = 0;  random_mix(N_RANDOM / 4);  drain_results();
        src_idle = 0;  snk_stall = 51; random_mix(N_RANDOM / 4);  drain_results();
        src_idle = 16; snk_stall = 16; random_mix(N_RANDOM / 4);  drain_results();

        src_idle = 0;  snk_stall = 0;
        send_checked(ACT_INSERT, ID_W'(((newest_id >> 8) + 1) << 8), 32'sd1, 32'sd2);
        send_checked(ACT_INSERT, ID_W'(newest_id + 1), 32'sd3, 32'sd4);
        send_checked(ACT_INSERT, 26'h3ffffff, $urandom, $urandom);
        src_idle = 16; snk_stall = 16;
        for (int k = 0; k < 20; k++)
            send_checked(ACT_LOOKUP, (k % 2) ? ID_W'($urandom) : stored_ids[$urandom_range(
                         stored_ids.size() - 1)], $urandom, $urandom);

        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected transactions never arrived", pending_results.size());
            fail_count++;
        end
        $display("covered %0d results, %0d successful lookups, store holds %0d chunks",
                 result_count, ok_lookups, chunks_used);
        $display("and %0d entries, under four idle/stall mixes", entries_used);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
